// ===== design/kpd_pkg.sv =====
package kpd_pkg;

    localparam int COLUMNS   = 4;
    localparam int COL_W     = 2;
    localparam int ROW_W     = 4;
    localparam int TIME_W    = 32;
    localparam int KEY_W     = COL_W + ROW_W;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WINDOW = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET      = 16'd200;
    localparam logic [CFG_W-1:0] REPEAT_WINDOW_RESET = 16'd20;

    typedef struct packed {
        logic              row_active;
        logic [ROW_W-1:0]  row_index;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_in_stage;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

// ===== design/kpd_in_if.sv =====
interface kpd_in_if import kpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              row_active;
    logic [ROW_W-1:0]  row_index;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output row_active, output row_index, output now_ms,
                    input ready);
    modport sink (input valid, input row_active, input row_index, input now_ms,
                  output ready);
endinterface

// ===== design/kpd_out_if.sv =====
interface kpd_out_if import kpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             key_valid;
    logic [KEY_W-1:0] key_code;
    logic             repeating;
    logic [COL_W-1:0] next_column;

    modport source (output valid, output key_valid, output key_code, output repeating,
                    output next_column, input ready);
    modport sink (input valid, input key_valid, input key_code, input repeating,
                  input next_column, output ready);
endinterface

// ===== design/kpd_in_reg.sv =====
module kpd_in_reg import kpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kpd_in_if.sink    i_in,
    input  logic      i_advance,
    output t_in_stage o_stage
);

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.row_active <= i_in.row_active;
            r_item.row_index  <= i_in.row_index;
            r_item.now_ms     <= i_in.now_ms;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

// ===== design/kpd_engine.sv =====
module kpd_engine import kpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_stage i_stage,
    input  t_cfg_wr   i_cfg,
    output logic      o_advance,
    kpd_out_if.source o_out
);

    logic [CFG_W-1:0]  r_debounce_ms;
    logic [CFG_W-1:0]  r_repeat_window_ms;
    logic [COL_W-1:0]  r_col;
    logic              r_pend_valid;
    logic [KEY_W-1:0]  r_pend_key;
    logic              r_held_valid;
    logic [KEY_W-1:0]  r_held_key;
    logic              r_repeat_mode;
    logic [TIME_W-1:0] r_deb_start;
    logic [TIME_W-1:0] r_rep_start;

    logic              r_out_valid;
    logic              r_key_valid;
    logic [KEY_W-1:0]  r_key_code;
    logic              r_repeating;
    logic [COL_W-1:0]  r_next_column;

    logic [COL_W-1:0]  n_col;
    logic              n_pend_valid;
    logic [KEY_W-1:0]  n_pend_key;
    logic              n_held_valid;
    logic [KEY_W-1:0]  n_held_key;
    logic              n_repeat_mode;
    logic [TIME_W-1:0] n_deb_start;
    logic [TIME_W-1:0] n_rep_start;
    logic              n_key_valid;
    logic [KEY_W-1:0]  n_key_code;
    logic              n_repeating;

    logic [KEY_W-1:0]  code;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] rep_diff;
    logic [TIME_W-1:0] deb_diff;
    logic              rep_elapsed;
    logic              deb_elapsed;
    logic              fire;

    assign o_advance = !r_out_valid || o_out.ready;
    assign fire      = i_stage.valid && o_advance;

    assign now         = i_stage.item.now_ms;
    assign code        = {r_col, i_stage.item.row_index};
    assign rep_diff    = now - r_rep_start;
    assign rep_elapsed = rep_diff >= TIME_W'(r_repeat_window_ms);

    always_comb begin
        n_pend_valid  = r_pend_valid;
        n_pend_key    = r_pend_key;
        n_held_valid  = r_held_valid;
        n_held_key    = r_held_key;
        n_repeat_mode = r_repeat_mode;
        n_deb_start   = r_deb_start;
        n_rep_start   = r_rep_start;
        n_key_valid   = 1'b0;
        n_key_code    = '0;
        n_repeating   = 1'b0;

        // idle window clears repeat state
        if (!i_stage.item.row_active && rep_elapsed) begin
            n_repeat_mode = 1'b0;
            n_held_valid  = 1'b0;
        end

        if (i_stage.item.row_active && !(r_pend_valid && (r_pend_key == code))) begin
            if (r_held_valid && (r_held_key == code) && !rep_elapsed) begin
                n_repeat_mode = 1'b1;
                n_rep_start   = now;
            end else begin
                n_pend_valid  = 1'b1;
                n_pend_key    = code;
                n_deb_start   = now;
                n_held_valid  = 1'b0;
                n_repeat_mode = 1'b0;
            end
        end

        deb_diff    = now - n_deb_start;
        deb_elapsed = deb_diff >= TIME_W'(r_debounce_ms);

        if (!n_repeat_mode && n_pend_valid && deb_elapsed) begin
            n_key_valid  = 1'b1;
            n_key_code   = n_pend_key;
            n_held_valid = 1'b1;
            n_held_key   = n_pend_key;
            n_pend_valid = 1'b0;
            n_rep_start  = now;
        end else if (n_repeat_mode && n_held_valid) begin
            n_key_valid = 1'b1;
            n_repeating = 1'b1;
            n_key_code  = n_held_key;
        end

        n_col = (r_col >= LAST_COL) ? '0 : r_col + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms      <= DEBOUNCE_RESET;
            r_repeat_window_ms <= REPEAT_WINDOW_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_DEBOUNCE: begin
                    r_debounce_ms <= i_cfg.data;
                end
                CFG_REPEAT_WINDOW: begin
                    r_repeat_window_ms <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_pend_valid  <= 1'b0;
            r_held_valid  <= 1'b0;
            r_repeat_mode <= 1'b0;
            r_deb_start   <= '0;
            r_rep_start   <= '0;
        end else if (fire) begin
            r_col         <= n_col;
            r_pend_valid  <= n_pend_valid;
            r_held_valid  <= n_held_valid;
            r_repeat_mode <= n_repeat_mode;
            r_deb_start   <= n_deb_start;
            r_rep_start   <= n_rep_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend_key <= n_pend_key;
            r_held_key <= n_held_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_key_valid   <= n_key_valid;
            r_key_code    <= n_key_code;
            r_repeating   <= n_repeating;
            r_next_column <= n_col;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.key_valid   = r_key_valid;
    assign o_out.key_code    = r_key_code;
    assign o_out.repeating   = r_repeating;
    assign o_out.next_column = r_next_column;

endmodule

// ===== design/keypad_scan_debounce_repeat_core.sv =====
// channel    dir   handshake      payload
// i_in       in    valid/ready    row_active, row_index[3:0], now_ms[31:0]
// o_out      out   valid/ready    key_valid, key_code[5:0], repeating, next_column[1:0]
// i_cfg_*    in    write enable   i_cfg_idx[0:0], i_cfg_data[15:0]
//
// one request per cycle sustained while o_out accepts results; an accepted request passes
// the input register, then the result register, around the scan/debounce logic
// i_rst_n is synchronous, active low; clears scan, debounce and repeat state, loads
// register defaults
// a stalled o_out holds its result while one more request waits in the input register
module keypad_scan_debounce_repeat_core import kpd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kpd_in_if.sink               i_in,
    kpd_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_in_stage stage;
    t_cfg_wr   cfg;
    logic      advance;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    kpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    kpd_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .i_cfg     (cfg),
        .o_advance (advance),
        .o_out     (o_out)
    );

endmodule

// ===== design/kpd_checker.sv =====
module kpd_checker import kpd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_key_valid,
    input logic [KEY_W-1:0] i_key_code,
    input logic             i_repeating,
    input logic [COL_W-1:0] i_next_column
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_key_valid) && $stable(i_key_code)
             && $stable(i_repeating) && $stable(i_next_column)))
        else $error("stalled result changed");

    a_idle_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_key_valid) |-> (i_key_code == '0 && !i_repeating))
        else $error("no report but code or repeat flag set");

    a_rep_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_repeating) |-> i_key_valid)
        else $error("repeat flag without report");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind keypad_scan_debounce_repeat_core kpd_checker u_kpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_key_valid   (o_out.key_valid),
    .i_key_code    (o_out.key_code),
    .i_repeating   (o_out.repeating),
    .i_next_column (o_out.next_column)
);

// ===== bench/kpd_report_check.sv =====
module kpd_report_check import kpd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kpd_in_if                    i_in,
    kpd_out_if                   i_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic             key_valid;
        logic [KEY_W-1:0] key_code;
        logic             repeating;
        logic [COL_W-1:0] next_column;
    } t_key_report;

    logic [CFG_W-1:0]  debounce_ms;
    logic [CFG_W-1:0]  repeat_window_ms;
    logic [COL_W-1:0]  scan_column;
    logic              pending_vld;
    logic [KEY_W-1:0]  pending_key;
    logic              held_vld;
    logic [KEY_W-1:0]  held_key;
    logic              repeat_mode;
    logic [TIME_W-1:0] debounce_start;
    logic [TIME_W-1:0] repeat_start;
    t_key_report       expected_reports[$];
    int                fail_count;

    // wrapping difference, a zero delay has always elapsed
    function automatic logic elapsed(input logic [TIME_W-1:0] now_t,
                                     input logic [TIME_W-1:0] start_t,
                                     input logic [CFG_W-1:0]  delay_ms);
        logic [TIME_W-1:0] diff;
        diff = now_t - start_t;
        return diff >= TIME_W'(delay_ms);
    endfunction

    function automatic t_key_report scan_tick(input logic              active,
                                              input logic [ROW_W-1:0]  row,
                                              input logic [TIME_W-1:0] now_t);
        t_key_report      rpt;
        logic [KEY_W-1:0] code;
        rpt  = '0;
        code = {scan_column, row};
        if (!active && elapsed(now_t, repeat_start, repeat_window_ms)) begin
            repeat_mode = 1'b0;
            held_vld    = 1'b0;
        end
        if (active && !(pending_vld && pending_key == code)) begin
            if (held_vld && held_key == code &&
                !elapsed(now_t, repeat_start, repeat_window_ms)) begin
                repeat_mode  = 1'b1;
                repeat_start = now_t;
            end else begin
                pending_vld    = 1'b1;
                pending_key    = code;
                debounce_start = now_t;
                held_vld       = 1'b0;
                repeat_mode    = 1'b0;
            end
        end
        if (!repeat_mode && pending_vld && elapsed(now_t, debounce_start, debounce_ms)) begin
            rpt.key_valid = 1'b1;
            rpt.key_code  = pending_key;
            held_vld      = 1'b1;
            held_key      = pending_key;
            pending_vld   = 1'b0;
            repeat_start  = now_t;
        end else if (repeat_mode && held_vld) begin
            rpt.key_valid = 1'b1;
            rpt.repeating = 1'b1;
            rpt.key_code  = held_key;
        end
        if (int'(scan_column) + 1 >= COLUMNS) begin
            scan_column = '0;
        end else begin
            scan_column = scan_column + 1'b1;
        end
        rpt.next_column = scan_column;
        return rpt;
    endfunction

    always @(posedge i_clk) begin
        t_key_report want;
        if (!i_rst_n) begin
            debounce_ms      = DEBOUNCE_RESET;
            repeat_window_ms = REPEAT_WINDOW_RESET;
            scan_column      = '0;
            pending_vld      = 1'b0;
            pending_key      = '0;
            held_vld         = 1'b0;
            held_key         = '0;
            repeat_mode      = 1'b0;
            debounce_start   = '0;
            repeat_start     = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEBOUNCE) begin
                    debounce_ms = i_cfg_data;
                end else if (i_cfg_idx == CFG_REPEAT_WINDOW) begin
                    repeat_window_ms = i_cfg_data;
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_reports.push_back(scan_tick(i_in.row_active, i_in.row_index,
                                                     i_in.now_ms));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    $error("result with no request waiting: key_code %0d", i_out.key_code);
                end else begin
                    want = expected_reports.pop_front();
                    if (i_out.key_valid !== want.key_valid) begin
                        fail_count++;
                        $error("key_valid: expected %0d, got %0d",
                               want.key_valid, i_out.key_valid);
                    end
                    if (i_out.key_code !== want.key_code) begin
                        fail_count++;
                        $error("key_code: expected %0d, got %0d",
                               want.key_code, i_out.key_code);
                    end
                    if (i_out.repeating !== want.repeating) begin
                        fail_count++;
                        $error("repeating: expected %0d, got %0d",
                               want.repeating, i_out.repeating);
                    end
                    if (i_out.next_column !== want.next_column) begin
                        fail_count++;
                        $error("next_column: expected %0d, got %0d",
                               want.next_column, i_out.next_column);
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = expected_reports.size();
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import kpd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 180;
    localparam int PHASES      = 7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic [CFG_W-1:0]     cur_deb;
    logic [CFG_W-1:0]     cur_win;
    logic [TIME_W-1:0]    clock_ms;
    int                   fail_count;
    int                   pending;
    int                   sent_count;
    int                   phase_items;
    int                   phase_idx;
    int                   cycle_count;

    kpd_in_if  in_ch ();
    kpd_out_if out_ch ();

    keypad_scan_debounce_repeat_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    kpd_report_check report_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(4, 40));
    endfunction

    task automatic send_scan(input logic act, input logic [ROW_W-1:0] row,
                             input logic [TIME_W-1:0] t_ms, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.row_active = act;
        in_ch.row_index  = row;
        in_ch.now_ms     = t_ms;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_count++;
        phase_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        int last_hold;
        last_hold    = -1;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if ((phase_idx == 1 || phase_idx == 5) && phase_idx != last_hold) begin
                // long hold-off so the block backs up and stalls its input
                last_hold    = phase_idx;
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_ch.ready = 1'b1;
            end else begin
                stall        = pick_gap();
                out_ch.ready = (stall == 0);
                if (stall > 0) begin
                    repeat (stall) @(negedge clk);
                    out_ch.ready = 1'b1;
                end
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(10, 60)) @(negedge clk);
                end else begin
                    repeat ($urandom_range(0, 3)) @(negedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("keypad_scan_debounce_repeat_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        int              key_col;
        logic [ROW_W-1:0] key_row;
        int unsigned     coarse;
        int unsigned     fine;
        int              n1;
        int              n2;
        int              n3;
        int              col;
        bit              no_gap;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.row_active = 1'b0;
        in_ch.row_index  = '0;
        in_ch.now_ms     = '0;
        sent_count       = 0;
        phase_items      = 0;
        phase_idx        = -1;
        cur_deb          = DEBOUNCE_RESET;
        cur_win          = REPEAT_WINDOW_RESET;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: report, repeat, window clear, debounce across the timestamp wrap
        send_scan(1'b0, 4'hF, 32'h0000_0000, 1'b0);
        send_scan(1'b1, 4'h0, 32'h0000_0001, 1'b0);
        send_scan(1'b0, 4'h0, 32'h0000_0032, 1'b0);
        send_scan(1'b0, 4'h0, 32'h0000_0096, 1'b0);
        send_scan(1'b0, 4'h0, 32'h0000_00C9, 1'b0);
        send_scan(1'b1, 4'h0, 32'h0000_00CD, 1'b0);
        send_scan(1'b0, 4'h3, 32'h0000_00D2, 1'b0);
        send_scan(1'b0, 4'h3, 32'h0000_00E6, 1'b0);
        send_scan(1'b1, 4'hF, 32'hFFFF_FFF0, 1'b0);
        send_scan(1'b0, 4'h0, 32'hFFFF_FFFF, 1'b0);
        send_scan(1'b0, 4'h0, 32'h0000_0050, 1'b0);
        send_scan(1'b0, 4'h0, 32'h0000_00C0, 1'b0);
        send_scan(1'b1, 4'hF, 32'h0000_00C5, 1'b0);
        send_scan(1'b1, 4'h7, 32'h0000_00C8, 1'b0);
        send_scan(1'b1, 4'h7, 32'hFFFF_FFFF, 1'b0);
        send_scan(1'b1, 4'hF, 32'hFFFF_FFFF, 1'b0);
        clock_ms = 32'h0000_1000;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    cur_deb = '0;
                    cur_win = '0;
                end
                1: begin
                    cur_deb = '1;
                    cur_win = '1;
                end
                2: begin
                    cur_deb = 16'd50;
                    cur_win = 16'd30;
                end
                3: begin
                    cur_deb = CFG_W'($urandom_range(0, 400));
                    cur_win = CFG_W'($urandom_range(0, 60));
                end
                4: begin
                    cur_deb = '1;
                    cur_win = '0;
                end
                5: begin
                    cur_deb = '0;
                    cur_win = '1;
                end
                default: begin
                    cur_deb = DEBOUNCE_RESET;
                    cur_win = REPEAT_WINDOW_RESET;
                end
            endcase
            write_reg(CFG_DEBOUNCE, cur_deb);
            write_reg(CFG_REPEAT_WINDOW, cur_win);
            phase_items = 0;
            phase_idx   = p;
            coarse      = cur_deb / 3 + 1;
            fine        = cur_win / 6 + 1;

            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1) == 1) begin
                        clock_ms = $urandom;
                    end else begin
                        clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 4 * coarse));
                    end
                end
                if ($urandom_range(0, 6) == 0) begin
                    // noise: unrelated ticks at arbitrary times
                    repeat ($urandom_range(1, 8)) begin
                        clock_ms = $urandom;
                        send_scan(1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 15)),
                                  clock_ms, 1'b0);
                    end
                end else begin
                    // key press: settle with coarse steps, hold with fine ones, release
                    key_col = int'($urandom_range(0, COLUMNS - 1));
                    key_row = ROW_W'($urandom_range(0, 15));
                    no_gap  = ($urandom_range(0, 3) == 0);
                    n1      = int'($urandom_range(1, 10));
                    n2      = int'($urandom_range(4, 40));
                    n3      = int'($urandom_range(1, 6));
                    for (int t = 0; t < n1 + n2; t++) begin
                        clock_ms = clock_ms + TIME_W'($urandom_range(0, t < n1 ? coarse : fine));
                        col      = sent_count % COLUMNS;
                        if ($urandom_range(0, 19) == 0) begin
                            send_scan(1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 15)),
                                      $urandom, no_gap);
                        end else if ($urandom_range(0, 9) == 0) begin
                            send_scan(col == key_col, ROW_W'($urandom_range(0, 15)),
                                      clock_ms, no_gap);
                        end else begin
                            send_scan(col == key_col, key_row, clock_ms, no_gap);
                        end
                    end
                    repeat (n3) begin
                        clock_ms = clock_ms + TIME_W'($urandom_range(0, cur_win / 2 + 1));
                        send_scan(1'b0, ROW_W'($urandom_range(0, 15)), clock_ms, no_gap);
                    end
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("keypad_scan_debounce_repeat_core: match");
        end else begin
            $display("keypad_scan_debounce_repeat_core: mismatch");
        end
        $finish;
    end

endmodule
